>>> sv/rau_pkg.sv
// Package for the rational arithmetic unit: operation codes, controller states,
// and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none
package rau_pkg;
	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int IN_WIDTH = 16;
	localparam int OP_WIDTH = 3;
	localparam int RES_NUM_WIDTH = 33;
	localparam int RES_DEN_WIDTH = 32;
	localparam int S_DATA_WIDTH = 64;
	localparam int M_DATA_WIDTH = 72;

	localparam logic [OP_WIDTH-1:0] OP_ADD = 3'd0;
	localparam logic [OP_WIDTH-1:0] OP_SUB = 3'd1;
	localparam logic [OP_WIDTH-1:0] OP_MUL = 3'd2;
	localparam logic [OP_WIDTH-1:0] OP_DIV = 3'd3;
	localparam logic [OP_WIDTH-1:0] OP_CMP = 3'd4;
	localparam logic [OP_WIDTH-1:0] OP_RED = 3'd5;

	localparam logic [1:0] ORD_LESS = 2'd0;
	localparam logic [1:0] ORD_EQUAL = 2'd1;
	localparam logic [1:0] ORD_GREATER = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_C,
		ST_MUL_D,
		ST_GCD_INIT,
		ST_GCD_RUN,
		ST_DIV_RUN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_a;
		logic mul_b;
		logic mul_c;
		logic mul_d;
		logic gcd_init;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic gcd_done;
		logic div_done;
	} sts_t;
endpackage
`default_nettype wire

>>> sv/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: stream ports, controller and datapath.
// Depends on rau_pkg, rau_ctrl and rau_dp.
//
// Usage: a request word on the slave stream carries two signed fractions in
// s_axis_tdata and the operation in s_axis_tuser (add, subtract, multiply,
// divide, compare, reduce first). One result word leaves on the master stream.
// Results are cross-multiplied and reduced by the gcd of their magnitudes.
// Sequence: the products and setup, then the binary gcd at one step per cycle,
// with the divider set up as the gcd ends, then a two-lane restoring divider,
// then the load of the output register; the time from acceptance to
// m_axis_tvalid varies with the gcd loop.
// One request is worked on at a time; s_axis_tready is high only while the
// unit is idle.
// The result sits in an output register; a stall on m_axis_tready holds it and
// the unit takes the next request meanwhile, finishing it only once the
// register is free. Reset clears the controller and the output valid flag.
`default_nettype none
module rational_arithmetic_unit #(
	parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// a_num [15:0], a_den [31:16], b_num [47:32], b_den [63:48]
	input  wire logic [rau_pkg::S_DATA_WIDTH-1:0]  s_axis_tdata,
	// req_type [2:0]
	input  wire logic [rau_pkg::OP_WIDTH-1:0]      s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// res_num [32:0], res_den [64:33], order [66:65], bad_den [67], zero [71:68]
	output logic [rau_pkg::M_DATA_WIDTH-1:0]       m_axis_tdata
);
	rau_pkg::cmd_t cmd;
	rau_pkg::sts_t sts;
	logic signed [rau_pkg::RES_NUM_WIDTH-1:0] res_num;
	logic signed [rau_pkg::RES_DEN_WIDTH-1:0] res_den;
	logic [1:0] order;
	logic bad_den;

	rau_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.sts(sts),
		.cmd(cmd)
	);

	rau_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.req_type(s_axis_tuser),
		.a_num(s_axis_tdata[15:0]),
		.a_den(s_axis_tdata[31:16]),
		.b_num(s_axis_tdata[47:32]),
		.b_den(s_axis_tdata[63:48]),
		.res_num(res_num),
		.res_den(res_den),
		.order(order),
		.bad_den(bad_den)
	);

	assign m_axis_tdata = {4'd0, bad_den, order, res_den, res_num};
endmodule
`default_nettype wire

>>> sv/rau_ctrl.sv
// Controller of the rational arithmetic unit: sequences products, gcd and division.
// Depends on rau_pkg.
`default_nettype none
module rau_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire rau_pkg::sts_t sts,
	output rau_pkg::cmd_t      cmd
);
	rau_pkg::state_t state_q, state_n;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready = (state_q == rau_pkg::ST_IDLE);

	always_comb begin
		state_n = state_q;
		case (state_q)
			rau_pkg::ST_IDLE: if (in_valid) state_n = rau_pkg::ST_MUL_A;
			rau_pkg::ST_MUL_A: state_n = rau_pkg::ST_MUL_B;
			rau_pkg::ST_MUL_B: state_n = rau_pkg::ST_MUL_C;
			rau_pkg::ST_MUL_C: state_n = rau_pkg::ST_MUL_D;
			rau_pkg::ST_MUL_D: state_n = rau_pkg::ST_GCD_INIT;
			rau_pkg::ST_GCD_INIT: state_n = rau_pkg::ST_GCD_RUN;
			rau_pkg::ST_GCD_RUN: if (sts.gcd_done) state_n = rau_pkg::ST_DIV_RUN;
			rau_pkg::ST_DIV_RUN: if (sts.div_done) state_n = rau_pkg::ST_FINISH;
			rau_pkg::ST_FINISH: if (out_free) state_n = rau_pkg::ST_IDLE;
			default: state_n = rau_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			rau_pkg::ST_IDLE: cmd.load = in_valid;
			rau_pkg::ST_MUL_A: cmd.mul_a = 1'b1;
			rau_pkg::ST_MUL_B: cmd.mul_b = 1'b1;
			rau_pkg::ST_MUL_C: cmd.mul_c = 1'b1;
			rau_pkg::ST_MUL_D: cmd.mul_d = 1'b1;
			rau_pkg::ST_GCD_INIT: cmd.gcd_init = 1'b1;
			rau_pkg::ST_GCD_RUN: begin
				cmd.gcd_step = !sts.gcd_done;
				cmd.div_init = sts.gcd_done;
			end
			rau_pkg::ST_DIV_RUN: cmd.div_step = !sts.div_done;
			rau_pkg::ST_FINISH: cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rau_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

>>> sv/rau_dp.sv
// Datapath of the rational arithmetic unit: shared multiplier, binary gcd,
// two-lane restoring divider and result register. Depends on rau_pkg.
`default_nettype none
module rau_dp #(
	parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire rau_pkg::cmd_t                     cmd,
	output rau_pkg::sts_t                          sts,
	input  wire logic [rau_pkg::OP_WIDTH-1:0]      req_type,
	input  wire logic [rau_pkg::IN_WIDTH-1:0]      a_num,
	input  wire logic [rau_pkg::IN_WIDTH-1:0]      a_den,
	input  wire logic [rau_pkg::IN_WIDTH-1:0]      b_num,
	input  wire logic [rau_pkg::IN_WIDTH-1:0]      b_den,
	output logic signed [rau_pkg::RES_NUM_WIDTH-1:0] res_num,
	output logic signed [rau_pkg::RES_DEN_WIDTH-1:0] res_den,
	output logic [1:0]                             order,
	output logic                                   bad_den
);
	localparam int W = OPERAND_WIDTH;
	localparam int PW = 2 * W;
	localparam int NW = 2 * W + 1;
	localparam int KW = $clog2(NW + 1);

	logic [rau_pkg::OP_WIDTH-1:0] op_q;
	logic signed [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [W-1:0] ma, mb;
	logic signed [PW-1:0] prod_s1;
	logic signed [NW-1:0] num_q, den_q;
	logic [NW-1:0] x_q, y_q, g_q, qa_q, qb_q, ra_q, rb_q;
	logic [KW-1:0] k_q, cnt_q;
	logic num_neg_q, den_neg_q;
	logic [NW-1:0] x_n, y_n;
	logic [KW-1:0] k_n;
	logic [NW:0] rta, rtb, da, db;
	logic gea, geb;
	logic [31:0] ext_an, ext_ad, ext_bn, ext_bd;
	logic signed [NW-1:0] prod_ext, num_fin, den_fin;
	logic signed [63:0] num64, den64;
	logic is_cmp, bad_n, less;
	logic [1:0] order_n;

	assign ext_an = {16'd0, a_num};
	assign ext_ad = {16'd0, a_den};
	assign ext_bn = {16'd0, b_num};
	assign ext_bd = {16'd0, b_den};

	always_comb begin
		ma = an_q;
		mb = bd_q;
		if (cmd.mul_a) begin
			ma = an_q;
			mb = (op_q == rau_pkg::OP_MUL) ? bn_q : bd_q;
		end else if (cmd.mul_b) begin
			ma = ad_q;
			mb = bn_q;
		end else begin
			ma = ad_q;
			mb = (op_q == rau_pkg::OP_DIV) ? bn_q : bd_q;
		end
	end

	assign prod_ext = NW'(prod_s1);

	always_comb begin
		x_n = x_q;
		y_n = y_q;
		k_n = k_q;
		if (!x_q[0] && !y_q[0]) begin
			x_n = x_q >> 1;
			y_n = y_q >> 1;
			k_n = k_q + 1'b1;
		end else if (!x_q[0]) begin
			x_n = x_q >> 1;
		end else if (!y_q[0]) begin
			y_n = y_q >> 1;
		end else if (x_q >= y_q) begin
			x_n = (x_q - y_q) >> 1;
		end else begin
			y_n = (y_q - x_q) >> 1;
		end
	end

	assign sts.gcd_done = (x_q == '0) || (y_q == '0);
	assign sts.div_done = (cnt_q == '0);

	assign rta = {ra_q, qa_q[NW-1]};
	assign rtb = {rb_q, qb_q[NW-1]};
	assign gea = rta >= {1'b0, g_q};
	assign geb = rtb >= {1'b0, g_q};
	assign da = rta - {1'b0, g_q};
	assign db = rtb - {1'b0, g_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req_type;
			an_q <= ext_an[W-1:0];
			ad_q <= ext_ad[W-1:0];
			bn_q <= ext_bn[W-1:0];
			bd_q <= ext_bd[W-1:0];
		end
		if (cmd.mul_a || cmd.mul_b || cmd.mul_c) prod_s1 <= ma * mb;
		if (cmd.mul_b) num_q <= prod_ext;
		if (cmd.mul_c) begin
			if (op_q == rau_pkg::OP_ADD) num_q <= num_q + prod_ext;
			else if (op_q == rau_pkg::OP_SUB || op_q == rau_pkg::OP_CMP)
				num_q <= num_q - prod_ext;
			else if (op_q > rau_pkg::OP_CMP) num_q <= NW'(an_q);
		end
		if (cmd.mul_d) den_q <= (op_q > rau_pkg::OP_CMP) ? NW'(ad_q) : prod_ext;
		if (cmd.gcd_init) begin
			x_q <= num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
			y_q <= den_q[NW-1] ? NW'(-den_q) : NW'(den_q);
			k_q <= '0;
			num_neg_q <= num_q[NW-1];
			den_neg_q <= den_q[NW-1];
		end
		if (cmd.gcd_step) begin
			x_q <= x_n;
			y_q <= y_n;
			k_q <= k_n;
		end
		if (cmd.div_init) begin
			g_q <= (x_q | y_q) << k_q;
			qa_q <= num_neg_q ? NW'(-num_q) : NW'(num_q);
			qb_q <= den_neg_q ? NW'(-den_q) : NW'(den_q);
			ra_q <= '0;
			rb_q <= '0;
		end
		if (cmd.div_step) begin
			ra_q <= gea ? da[NW-1:0] : rta[NW-1:0];
			rb_q <= geb ? db[NW-1:0] : rtb[NW-1:0];
			qa_q <= {qa_q[NW-2:0], gea};
			qb_q <= {qb_q[NW-2:0], geb};
		end
		if (cmd.out_load) begin
			res_num <= is_cmp ? '0 : num64[rau_pkg::RES_NUM_WIDTH-1:0];
			res_den <= is_cmp ? '0 : den64[rau_pkg::RES_DEN_WIDTH-1:0];
			order <= order_n;
			bad_den <= bad_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (cmd.div_init) cnt_q <= KW'(NW);
		else if (cmd.div_step) cnt_q <= cnt_q - 1'b1;
	end

	always_comb begin
		is_cmp = (op_q == rau_pkg::OP_CMP);
		if (g_q == '0) begin
			num_fin = num_q;
			den_fin = den_q;
		end else begin
			num_fin = num_neg_q ? -$signed(qa_q) : $signed(qa_q);
			den_fin = den_neg_q ? -$signed(qb_q) : $signed(qb_q);
		end
		num64 = 64'(num_fin);
		den64 = 64'(den_fin);
		if (is_cmp) bad_n = (ad_q == '0) || (bd_q == '0);
		else bad_n = (ad_q == '0) || (den_q == '0)
			|| (op_q <= rau_pkg::OP_DIV && bd_q == '0);
		less = num_q[NW-1] ^ (ad_q[W-1] ^ bd_q[W-1]);
		order_n = rau_pkg::ORD_EQUAL;
		if (is_cmp && !bad_n && num_q != '0)
			order_n = less ? rau_pkg::ORD_LESS : rau_pkg::ORD_GREATER;
	end
endmodule
`default_nettype wire

>>> tb/testbench.sv
// Testbench for rational_arithmetic_unit: directed table plus random fraction
// requests, each checked against the table or a behavioral predictor. Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	typedef struct packed {
		logic        bad;
		logic [1:0]  ord;
		logic [31:0] den;
		logic [32:0] num;
	} result_t;

	typedef struct {
		logic [2:0]  op;
		logic [15:0] an, ad, bn, bd;
		bit          typed;
		result_t     res;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [rau_pkg::S_DATA_WIDTH-1:0] s_axis_tdata = '0;
	logic [rau_pkg::OP_WIDTH-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [rau_pkg::M_DATA_WIDTH-1:0] m_axis_tdata;

	result_t pending[$];
	int errors = 0;
	int idle_cycles = 0;
	bit stim_done = 0;
	row_t dir[$];

	rational_arithmetic_unit uut (.*);

	always #10 clk = ~clk;

	function automatic longint unsigned mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic result_t fraction_result(logic [2:0] op, logic [15:0] an16,
			logic [15:0] ad16, logic [15:0] bn16, logic [15:0] bd16);
		longint an, ad, bn, bd, num, den, lhs, rhs;
		longint unsigned x, y, t;
		bit less;
		result_t r;
		an = $signed(an16); ad = $signed(ad16); bn = $signed(bn16); bd = $signed(bd16);
		num = 0; den = 0;
		r.ord = rau_pkg::ORD_EQUAL; r.bad = 0;
		if (op == rau_pkg::OP_CMP) begin
			if (ad == 0 || bd == 0) r.bad = 1;
			else begin
				lhs = an * bd; rhs = bn * ad;
				if (lhs != rhs) begin
					less = lhs < rhs;
					if ((ad < 0) != (bd < 0)) less = !less;
					r.ord = less ? rau_pkg::ORD_LESS : rau_pkg::ORD_GREATER;
				end
			end
		end else begin
			case (op)
				rau_pkg::OP_ADD: begin num = an * bd + ad * bn; den = ad * bd; end
				rau_pkg::OP_SUB: begin num = an * bd - ad * bn; den = ad * bd; end
				rau_pkg::OP_MUL: begin num = an * bn; den = ad * bd; end
				rau_pkg::OP_DIV: begin num = an * bd; den = ad * bn; end
				default: begin num = an; den = ad; end
			endcase
			if (ad == 0 || den == 0) r.bad = 1;
			if (op <= rau_pkg::OP_DIV && bd == 0) r.bad = 1;
			x = mag(num); y = mag(den);
			while (y != 0) begin
				t = x % y; x = y; y = t;
			end
			if (x > 1) begin
				num = num / longint'(x); den = den / longint'(x);
			end
		end
		r.num = num[32:0];
		r.den = den[31:0];
		return r;
	endfunction

	task automatic send_request(logic [2:0] op, logic [15:0] an, logic [15:0] ad,
			logic [15:0] bn, logic [15:0] bd, result_t want);
		int gap;
		if ($urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= {bd, bn, ad, an};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending.push_back(want);
		@(negedge clk);
	endtask

	function automatic row_t mk(logic [2:0] op, int an, int ad, int bn, int bd);
		row_t r;
		r.op = op; r.an = 16'(an); r.ad = 16'(ad); r.bn = 16'(bn); r.bd = 16'(bd);
		r.typed = 0;
		r.res = '0;
		return r;
	endfunction

	function automatic row_t mkx(logic [2:0] op, int an, int ad, int bn, int bd,
			longint n, longint d, logic [1:0] o, logic b);
		row_t r;
		r = mk(op, an, ad, bn, bd);
		r.typed = 1;
		r.res.num = 33'(n); r.res.den = 32'(d); r.res.ord = o; r.res.bad = b;
		return r;
	endfunction

	always @(posedge clk) begin
		result_t got, exp;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 20000) begin
				$display("[rational_arithmetic_unit] ERROR");
				$finish;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[67:0];
				if (pending.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					exp = pending.pop_front();
					if (got.num !== exp.num) begin
						$error("res_num exp %0h got %0h", exp.num, got.num); errors++;
					end
					if (got.den !== exp.den) begin
						$error("res_den exp %0h got %0h", exp.den, got.den); errors++;
					end
					if (got.ord !== exp.ord) begin
						$error("order exp %0d got %0d", exp.ord, got.ord); errors++;
					end
					if (got.bad !== exp.bad) begin
						$error("bad_den exp %0d got %0d", exp.bad, got.bad); errors++;
					end
				end
			end
		end
	end

	initial begin
		int phase;
		forever begin
			@(negedge clk);
			phase = $urandom_range(0, 2);
			if (phase == 0) m_axis_tready <= 1;
			else if (phase == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
			else m_axis_tready <= ($urandom_range(0, 1) == 0);
			repeat ($urandom_range(0, 30)) begin
				@(negedge clk);
				if (phase == 2) m_axis_tready <= 1'($urandom_range(0, 1));
			end
		end
	end

	initial begin
		logic [15:0] f[4];
		logic [2:0] op;
		row_t r;
		int sel;
		dir.push_back(mkx(rau_pkg::OP_ADD, 1, 2, 1, 3, 5, 6, rau_pkg::ORD_EQUAL, 0));
		dir.push_back(mkx(rau_pkg::OP_SUB, 1, 2, 1, 2, 0, 1, rau_pkg::ORD_EQUAL, 0));
		dir.push_back(mkx(rau_pkg::OP_MUL, 2, 3, 3, 4, 1, 2, rau_pkg::ORD_EQUAL, 0));
		dir.push_back(mkx(rau_pkg::OP_DIV, 1, 2, 1, 4, 2, 1, rau_pkg::ORD_EQUAL, 0));
		dir.push_back(mkx(rau_pkg::OP_CMP, 1, 2, 1, 3, 0, 0, rau_pkg::ORD_GREATER, 0));
		dir.push_back(mkx(rau_pkg::OP_CMP, 1, 3, 1, 2, 0, 0, rau_pkg::ORD_LESS, 0));
		dir.push_back(mkx(rau_pkg::OP_CMP, 2, 4, 1, 2, 0, 0, rau_pkg::ORD_EQUAL, 0));
		dir.push_back(mkx(rau_pkg::OP_CMP, 1, 0, 1, 2, 0, 0, rau_pkg::ORD_EQUAL, 1));
		dir.push_back(mkx(rau_pkg::OP_RED, 6, -4, 0, 0, 3, -2, rau_pkg::ORD_EQUAL, 0));
		dir.push_back(mkx(rau_pkg::OP_RED, 0, -5, 7, 7, 0, -1, rau_pkg::ORD_EQUAL, 0));
		dir.push_back(mkx(rau_pkg::OP_RED, -9, 0, 1, 1, -1, 0, rau_pkg::ORD_EQUAL, 1));
		dir.push_back(mkx(rau_pkg::OP_RED, 0, 0, 1, 1, 0, 0, rau_pkg::ORD_EQUAL, 1));
		dir.push_back(mkx(3'd6, 4, 8, 1, 1, 1, 2, rau_pkg::ORD_EQUAL, 0));
		dir.push_back(mkx(3'd7, -4, 8, 1, 1, -1, 2, rau_pkg::ORD_EQUAL, 0));
		dir.push_back(mkx(rau_pkg::OP_ADD, 1, 2, 1, 0, 1, 0, rau_pkg::ORD_EQUAL, 1));
		dir.push_back(mkx(rau_pkg::OP_DIV, 1, 2, 0, 3, 1, 0, rau_pkg::ORD_EQUAL, 1));
		dir.push_back(mk(rau_pkg::OP_MUL, -32768, -32768, -32768, -32768));
		dir.push_back(mk(rau_pkg::OP_ADD, -32768, 32767, -32768, 32767));
		dir.push_back(mk(rau_pkg::OP_SUB, 32767, -32768, -32768, 32767));
		dir.push_back(mk(rau_pkg::OP_DIV, -32768, 1, 1, -32768));
		dir.push_back(mk(rau_pkg::OP_CMP, -32768, -1, 32767, 1));
		dir.push_back(mk(rau_pkg::OP_MUL, 32767, 1, 32767, 1));
		dir.push_back(mk(rau_pkg::OP_ADD, -1, -1, -1, -1));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		foreach (dir[i]) begin
			r = dir[i];
			send_request(r.op, r.an, r.ad, r.bn, r.bd, r.typed ? r.res
				: fraction_result(r.op, r.an, r.ad, r.bn, r.bd));
		end

		for (int n = 0; n < 750; n++) begin
			if (n == 300) begin
				s_axis_tvalid <= 0;
				while (pending.size() != 0) @(negedge clk);
			end
			op = 3'($urandom_range(0, 7));
			for (int k = 0; k < 4; k++) begin
				sel = $urandom_range(0, 9);
				if (sel == 0) f[k] = 0;
				else if (sel == 1) f[k] = 16'h8000;
				else if (sel == 2) f[k] = 16'h7fff;
				else if (sel < 6) f[k] = 16'($urandom_range(0, 40) - 20);
				else f[k] = 16'($urandom);
			end
			send_request(op, f[0], f[1], f[2], f[3],
				fraction_result(op, f[0], f[1], f[2], f[3]));
		end
		s_axis_tvalid <= 0;
		while (pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("[rational_arithmetic_unit] OK");
		else
			$display("[rational_arithmetic_unit] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
